@@ src/cqr_pkg.sv @@
// Shared types and constants for the circular queue with in-place reverse.
package cqr_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int COUNT_W   = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH      = 3'd0,
    REQ_POP       = 3'd1,
    REQ_PEEK_HEAD = 3'd2,
    REQ_PEEK_TAIL = 3'd3,
    REQ_REVERSE   = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic rev_start;
    logic swap_rd;
    logic swap_wlo;
    logic swap_whi;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rev_work;
    logic last_pair;
    logic out_free;
  } sts_t;

endpackage

@@ src/cqr_ctrl.sv @@
// Controller state machine for the circular queue: sequences requests and reverse swaps.
module cqr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cqr_pkg::sts_t sts,
  output cqr_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_SW_RD  = 6'b000100,
    ST_SW_WLO = 6'b001000,
    ST_SW_WHI = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (sts.rev_work) begin
          cmd.rev_start = 1'b1;
          state_next    = ST_SW_RD;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_SW_RD: begin
        cmd.swap_rd = 1'b1;
        state_next  = ST_SW_WLO;
      end
      ST_SW_WLO: begin
        cmd.swap_wlo = 1'b1;
        state_next   = ST_SW_WHI;
      end
      ST_SW_WHI: begin
        cmd.swap_whi = 1'b1;
        state_next   = sts.last_pair ? ST_FIN : ST_SW_RD;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/cqr_dpath.sv @@
// Datapath for the circular queue: storage, head and tail pointers, count and result register.
module cqr_dpath #(
  parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cqr_pkg::cmd_t                      cmd,
  output cqr_pkg::sts_t                      sts,
  input  logic [cqr_pkg::REQ_W-1:0]          req_type,
  input  logic signed [cqr_pkg::DATA_W-1:0]  data_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [cqr_pkg::DATA_W-1:0]  data_out,
  output logic [cqr_pkg::COUNT_W-1:0]        count,
  output logic                               is_empty,
  output logic                               is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [cqr_pkg::DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]              head;
  logic [AW-1:0]              tail;
  logic [CW-1:0]              cnt;
  logic [cqr_pkg::REQ_W-1:0]  req_q;
  logic [cqr_pkg::DATA_W-1:0] din_q;
  logic [cqr_pkg::DATA_W-1:0] rd_a;
  logic [cqr_pkg::DATA_W-1:0] rd_b;
  logic [AW-1:0]              lo;
  logic [AW-1:0]              hi;
  logic [CW-1:0]              pairs;

  logic [AW-1:0]              head_next;
  logic [AW-1:0]              tail_next;
  logic [CW-1:0]              cnt_next;
  logic                       ok_next;
  logic [cqr_pkg::DATA_W-1:0] data_next;
  logic                       push_we;
  logic                       q_empty;
  logic                       q_full;
  logic [AW-1:0]              tail_inc;
  logic [AW-1:0]              head_inc;
  logic [CW+7:0]              cnt_wide;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [cqr_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]              raddr_a;

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  assign tail_inc = inc_wrap(tail);
  assign head_inc = inc_wrap(head);
  assign q_empty  = (cnt == '0);
  assign q_full   = (cnt == FULL_CNT);

  assign sts.rev_work  = (req_q == cqr_pkg::REQ_REVERSE) && (cnt > CW'(1));
  assign sts.last_pair = (pairs == CW'(1));
  assign sts.out_free  = !out_valid || out_ready;

  // Outcome of the request held in req_q, applied when the controller commits.
  always_comb begin
    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    ok_next   = 1'b0;
    data_next = '0;
    push_we   = 1'b0;
    unique case (req_q)
      cqr_pkg::REQ_PUSH: begin
        if (!q_full) begin
          tail_next = tail_inc;
          cnt_next  = cnt + 1'b1;
          push_we   = 1'b1;
          ok_next   = 1'b1;
        end
      end
      cqr_pkg::REQ_POP: begin
        if (!q_empty) begin
          head_next = head_inc;
          cnt_next  = cnt - 1'b1;
          ok_next   = 1'b1;
          data_next = rd_a;
        end
      end
      cqr_pkg::REQ_PEEK_HEAD, cqr_pkg::REQ_PEEK_TAIL: begin
        if (!q_empty) begin
          ok_next   = 1'b1;
          data_next = rd_a;
        end
      end
      cqr_pkg::REQ_REVERSE: begin
        ok_next = !q_empty;
      end
      cqr_pkg::REQ_CLEAR: begin
        head_next = '0;
        tail_next = LAST_IDX;
        cnt_next  = '0;
        ok_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cnt_wide = {8'b0, cnt_next};

  // Single write port shared by push and the two halves of a swap.
  always_comb begin
    we    = 1'b0;
    waddr = tail_inc;
    wdata = din_q;
    priority if (cmd.commit && push_we) begin
      we = 1'b1;
    end else if (cmd.swap_wlo) begin
      we    = 1'b1;
      waddr = lo;
      wdata = rd_b;
    end else if (cmd.swap_whi) begin
      we    = 1'b1;
      waddr = hi;
      wdata = rd_a;
    end else begin
      we = 1'b0;
    end
  end

  // The read for a pop or peek is issued as the request is accepted.
  always_comb begin
    if (cmd.accept) begin
      raddr_a = (req_type == cqr_pkg::REQ_PEEK_TAIL) ? tail : head;
    end else begin
      raddr_a = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept || cmd.swap_rd) begin
      rd_a <= mem[raddr_a];
    end
    if (cmd.swap_rd) begin
      rd_b <= mem[hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= LAST_IDX;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head      <= head_next;
        tail      <= tail_next;
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req_type;
      din_q <= data_in;
    end
    if (cmd.rev_start) begin
      lo    <= head;
      hi    <= tail;
      pairs <= cnt >> 1;
    end else if (cmd.swap_whi) begin
      lo    <= inc_wrap(lo);
      hi    <= dec_wrap(hi);
      pairs <= pairs - 1'b1;
    end
    if (cmd.commit) begin
      ok       <= ok_next;
      data_out <= data_next;
      count    <= cnt_wide[7:0];
      is_empty <= (cnt_next == '0);
      is_full  <= (cnt_next == FULL_CNT);
    end
  end

endmodule

@@ src/circular_queue_with_reverse_top.sv @@
// Top level of the circular queue of 32-bit words with push, pop, peeks, reverse and clear.
//
//   Channel   Direction  Handshake              Payload
//   request   in         in_valid / in_ready    req_type, data_in
//   result    out        out_valid / out_ready  ok, data_out, count, is_empty, is_full
//
// Push, pop, peeks, clear and unused codes first accept the request and issue the storage
// read, then apply it and load the result register.
// Reverse of two or more words also swaps the words pair by pair before the result is loaded;
// each swap reads both words, then writes them back one at a time on the single storage
// write port. Reverse of an empty or one-word queue is handled like the other requests.
// Reset empties the queue at once; storage contents are not cleared.
// A result waiting in the output register stalls the next request only at its final step.
module circular_queue_with_reverse_top #(
  parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cqr_pkg::REQ_W-1:0]          req_type,
  input  logic signed [cqr_pkg::DATA_W-1:0]  data_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [cqr_pkg::DATA_W-1:0]  data_out,
  output logic [cqr_pkg::COUNT_W-1:0]        count,
  output logic                               is_empty,
  output logic                               is_full
);

  cqr_pkg::cmd_t cmd;
  cqr_pkg::sts_t sts;

  cqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cqr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (req_type),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .data_out  (data_out),
    .count     (count),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

endmodule
